[sv/cspi_pkg.sv]
// cspi_pkg: shared types, character codes and default sizes for the
// comma separated integer parser; no dependencies
`default_nettype none

package cspi_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int LIMIT_BITS_DEF = 64;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	localparam logic [4:0] DIGIT_NONE = 5'd16;
	localparam logic [4:0] DIGIT_TEN  = 5'd10;

	typedef enum logic [6:0] {
		PH_BETWEEN = 7'b0000001,
		PH_SPACE   = 7'b0000010,
		PH_SIGN    = 7'b0000100,
		PH_ZERO    = 7'b0001000,
		PH_HEXPFX  = 7'b0010000,
		PH_DIGITS  = 7'b0100000,
		PH_ENDED   = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_OCT = 2'd1,
		BASE_HEX = 2'd2
	} base_t;

	typedef struct packed {
		logic value_valid;
		logic done_res;
		logic failed;
	} res_flags_t;

	function automatic logic [4:0] digit_of(input logic [7:0] c);
		logic [4:0] d;
		d = DIGIT_NONE;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = 5'(c - CH_ZERO);
		end else if (c >= CH_LA && c <= CH_LF) begin
			d = 5'(c - CH_LA) + DIGIT_TEN;
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = 5'(c - CH_UA) + DIGIT_TEN;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

[sv/cspi_digit_acc.sv]
// cspi_digit_acc: appends one digit to the token magnitude and flags
// overflow past the signed limit; uses cspi_pkg
`default_nettype none

module cspi_digit_acc
	import cspi_pkg::*;
#(
	parameter int LIMIT_BITS = LIMIT_BITS_DEF
) (
	input  wire logic [LIMIT_BITS-1:0] mag,
	input  wire base_t                 base,
	input  wire logic [3:0]            digit,
	output logic [LIMIT_BITS-1:0]      mag_next,
	output logic                       over
);

	localparam int PW = LIMIT_BITS + 4;
	localparam logic [PW-1:0] LIM = PW'(1) << (LIMIT_BITS - 1);

	logic [PW-1:0] mag_w;
	logic [PW-1:0] scaled;
	logic [PW-1:0] sum;

	always_comb begin
		mag_w = PW'(mag);
		case (base)
			BASE_HEX: scaled = mag_w << 4;
			BASE_OCT: scaled = mag_w << 3;
			BASE_DEC: scaled = (mag_w << 3) + (mag_w << 1);
			default:  scaled = (mag_w << 3) + (mag_w << 1);
		endcase
		sum      = scaled + PW'(digit);
		over     = sum > LIM;
		mag_next = sum[LIMIT_BITS-1:0];
	end

endmodule

`default_nettype wire

[sv/cspi_token_core.sv]
// cspi_token_core: token state registers and the per-character update,
// producing at most one result per request; uses cspi_pkg, cspi_digit_acc
`default_nettype none

module cspi_token_core
	import cspi_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int LIMIT_BITS = LIMIT_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic [7:0]            char_code,
	input  wire logic                  char_present,
	input  wire logic                  end_of_text,
	output logic                       res_fire,
	output res_flags_t                 res_flags,
	output logic [VALUE_BITS-1:0]      res_value,
	output logic [COUNT_BITS-1:0]      res_index,
	output logic [COUNT_BITS-1:0]      res_count
);

	localparam int EW = (VALUE_BITS > LIMIT_BITS + 1) ? VALUE_BITS : LIMIT_BITS + 1;

	phase_t                phase_q, phase_a, phase_b;
	logic                  neg_q, neg_a;
	base_t                 base_q, base_a;
	logic [LIMIT_BITS-1:0] mag_q, mag_a;
	logic                  ovf_q, ovf_a;
	logic                  err_q, err_b;
	logic [COUNT_BITS-1:0] cnt_q, cnt_b;

	logic [4:0]            digit;
	logic                  is_space;
	logic                  is_sign;
	logic                  ok_char;
	logic                  fin_req;
	logic                  nul_seen;
	logic                  fail_c;
	logic                  fail_f;
	logic                  emit;
	logic                  fits;
	logic [LIMIT_BITS-1:0] acc_mag;
	logic                  acc_over;
	logic signed [LIMIT_BITS:0] sval;
	logic [EW-1:0]         ext;

	cspi_digit_acc #(
		.LIMIT_BITS(LIMIT_BITS)
	) u_acc (
		.mag      (mag_q),
		.base     (base_q),
		.digit    (digit[3:0]),
		.mag_next (acc_mag),
		.over     (acc_over)
	);

	always_comb begin
		digit    = digit_of(char_code);
		is_space = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
		is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
		ok_char  = char_present && !err_q && (phase_q != PH_ENDED);

		phase_a  = phase_q;
		neg_a    = neg_q;
		base_a   = base_q;
		mag_a    = mag_q;
		ovf_a    = ovf_q;
		fin_req  = 1'b0;
		nul_seen = 1'b0;
		fail_c   = 1'b0;

		// character step without token finishing
		if (ok_char) begin
			if (char_code == CH_NUL) begin
				fin_req  = 1'b1;
				nul_seen = 1'b1;
			end else if (char_code == CH_COMMA) begin
				fin_req = 1'b1;
			end else begin
				case (phase_q)
					PH_BETWEEN, PH_SPACE: begin
						if (is_space) begin
							phase_a = PH_SPACE;
						end else if (is_sign) begin
							phase_a = PH_SIGN;
							neg_a   = (char_code == CH_MINUS);
						end else if (char_code == CH_ZERO) begin
							phase_a = PH_ZERO;
						end else if (digit < DIGIT_TEN) begin
							phase_a = PH_DIGITS;
							base_a  = BASE_DEC;
							mag_a   = LIMIT_BITS'(digit);
						end else begin
							fail_c = 1'b1;
						end
					end
					PH_SIGN: begin
						if (char_code == CH_ZERO) begin
							phase_a = PH_ZERO;
						end else if (digit < DIGIT_TEN) begin
							phase_a = PH_DIGITS;
							base_a  = BASE_DEC;
							mag_a   = LIMIT_BITS'(digit);
						end else begin
							fail_c = 1'b1;
						end
					end
					PH_ZERO: begin
						if (char_code == CH_LX || char_code == CH_UX) begin
							phase_a = PH_HEXPFX;
						end else if (digit < 5'd8) begin
							phase_a = PH_DIGITS;
							base_a  = BASE_OCT;
							mag_a   = LIMIT_BITS'(digit);
						end else begin
							fail_c = 1'b1;
						end
					end
					PH_HEXPFX: begin
						if (digit != DIGIT_NONE) begin
							phase_a = PH_DIGITS;
							base_a  = BASE_HEX;
							mag_a   = LIMIT_BITS'(digit);
						end else begin
							fail_c = 1'b1;
						end
					end
					PH_DIGITS: begin
						if ((base_q == BASE_HEX && digit != DIGIT_NONE) ||
						    (base_q == BASE_OCT && digit < 5'd8) ||
						    (base_q == BASE_DEC && digit < DIGIT_TEN)) begin
							if (!ovf_q) begin
								if (acc_over) begin
									ovf_a = 1'b1;
								end else begin
									mag_a = acc_mag;
								end
							end
						end else begin
							fail_c = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end

		if (fail_c) begin
			phase_a = PH_BETWEEN;
			neg_a   = 1'b0;
			base_a  = BASE_DEC;
			mag_a   = '0;
			ovf_a   = 1'b0;
		end
		err_b = err_q | fail_c;

		if (end_of_text && !err_b) begin
			fin_req = 1'b1;
		end

		// token finishing
		fits   = !ovf_a && (neg_a || !mag_a[LIMIT_BITS-1]);
		emit   = 1'b0;
		fail_f = 1'b0;
		if (fin_req) begin
			if (phase_a == PH_ZERO || phase_a == PH_DIGITS) begin
				if (fits) begin
					emit = 1'b1;
				end else begin
					fail_f = 1'b1;
				end
			end else if (phase_a != PH_BETWEEN && phase_a != PH_ENDED) begin
				fail_f = 1'b1;
			end
		end
		err_b   = err_b | fail_f;
		phase_b = (emit || fail_f) ? PH_BETWEEN : phase_a;
		if (nul_seen && !err_b) begin
			phase_b = PH_ENDED;
		end

		cnt_b = cnt_q;
		if (emit && cnt_q != '1) begin
			cnt_b = cnt_q + COUNT_BITS'(1);
		end

		sval = neg_a ? -$signed({1'b0, mag_a}) : $signed({1'b0, mag_a});
		ext  = EW'(sval);

		res_fire              = emit || end_of_text;
		res_flags.value_valid = emit;
		res_flags.done_res    = end_of_text;
		res_flags.failed      = end_of_text && err_b;
		res_value             = emit ? ext[VALUE_BITS-1:0] : '0;
		res_index             = emit ? cnt_q : '0;
		res_count             = end_of_text ? cnt_b : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BETWEEN;
			neg_q   <= 1'b0;
			base_q  <= BASE_DEC;
			mag_q   <= '0;
			ovf_q   <= 1'b0;
			err_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (step) begin
			if (end_of_text) begin
				phase_q <= PH_BETWEEN;
				neg_q   <= 1'b0;
				base_q  <= BASE_DEC;
				mag_q   <= '0;
				ovf_q   <= 1'b0;
				err_q   <= 1'b0;
				cnt_q   <= '0;
			end else begin
				phase_q <= phase_b;
				neg_q   <= (emit || fail_f) ? 1'b0 : neg_a;
				base_q  <= (emit || fail_f) ? BASE_DEC : base_a;
				mag_q   <= (emit || fail_f) ? '0 : mag_a;
				ovf_q   <= (emit || fail_f) ? 1'b0 : ovf_a;
				err_q   <= err_b;
				cnt_q   <= cnt_b;
			end
		end
	end

endmodule

`default_nettype wire

[sv/cspi_out_reg.sv]
// cspi_out_reg: result register on the output channel with valid/stall
// handshake; uses cspi_pkg
`default_nettype none

module cspi_out_reg
	import cspi_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire res_flags_t            flags,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic [COUNT_BITS-1:0] index,
	input  wire logic [COUNT_BITS-1:0] count,
	output logic                       free,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [VALUE_BITS-1:0]      number_value,
	output logic [COUNT_BITS-1:0]      number_index,
	output logic                       value_valid,
	output logic                       done_res,
	output logic                       failed,
	output logic [COUNT_BITS-1:0]      number_count
);

	logic                  valid_q;
	res_flags_t            flags_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [COUNT_BITS-1:0] index_q;
	logic [COUNT_BITS-1:0] count_q;

	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			flags_q <= flags;
			value_q <= value;
			index_q <= index;
			count_q <= count;
		end
	end

	assign out_valid    = valid_q;
	assign number_value = value_q;
	assign number_index = index_q;
	assign value_valid  = flags_q.value_valid;
	assign done_res     = flags_q.done_res;
	assign failed       = flags_q.failed;
	assign number_count = count_q;

endmodule

`default_nettype wire

[sv/comma_separated_integer_parser.sv]
// comma_separated_integer_parser: top level with input register, token core
// and result register; uses cspi_pkg, cspi_token_core, cspi_out_reg
//
// Parses a comma separated list of integers, one text byte per request, with
// strtol base-0 rules per token (white space, sign, 0x hex, leading-0 octal,
// decimal). A good token yields its low VALUE_BITS bits and its list index;
// the end-of-text request always yields a done result with failure flag and
// count. Throughput is one request per cycle while the result register is
// not stalled full; a result is registered when its request leaves the input
// register, by the combinational token update between the two registers.
`default_nettype none

module comma_separated_integer_parser
	import cspi_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int LIMIT_BITS = LIMIT_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            char_code,
	input  wire logic                  char_present,
	input  wire logic                  end_of_text,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [VALUE_BITS-1:0]      number_value,
	output logic [COUNT_BITS-1:0]      number_index,
	output logic                       value_valid,
	output logic                       done_res,
	output logic                       failed,
	output logic [COUNT_BITS-1:0]      number_count
);

	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  present_s1;
	logic                  last_s1;
	logic                  out_free;
	logic                  advance;
	logic                  res_fire;
	res_flags_t            res_flags;
	logic [VALUE_BITS-1:0] res_value;
	logic [COUNT_BITS-1:0] res_index;
	logic [COUNT_BITS-1:0] res_count;

	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1    <= char_code;
			present_s1 <= char_present;
			last_s1    <= end_of_text;
		end
	end

	cspi_token_core #(
		.VALUE_BITS(VALUE_BITS),
		.LIMIT_BITS(LIMIT_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.char_code    (char_s1),
		.char_present (present_s1),
		.end_of_text  (last_s1),
		.res_fire     (res_fire),
		.res_flags    (res_flags),
		.res_value    (res_value),
		.res_index    (res_index),
		.res_count    (res_count)
	);

	cspi_out_reg #(
		.VALUE_BITS(VALUE_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && res_fire),
		.flags        (res_flags),
		.value        (res_value),
		.index        (res_index),
		.count        (res_count),
		.free         (out_free),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.number_value (number_value),
		.number_index (number_index),
		.value_valid  (value_valid),
		.done_res     (done_res),
		.failed       (failed),
		.number_count (number_count)
	);

endmodule

`default_nettype wire

[sim/tb_top.sv]
// tb_top: self-checking bench for comma_separated_integer_parser; texts go in one byte per
// request, every number and done result is predicted and compared field by field
// depends on cspi_pkg and the parser rtl
`timescale 1ns / 1ps

module tb_top;
	import cspi_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_500_000;
	localparam int RANDOM_REQUESTS = 1060;
	localparam int BURST_TOKENS = 30;

	typedef struct packed {
		logic [VALUE_BITS_DEF-1:0] number_value;
		logic [COUNT_BITS_DEF-1:0] number_index;
		logic                      value_valid;
		logic                      done_res;
		logic                      failed;
		logic [COUNT_BITS_DEF-1:0] number_count;
	} number_result_t;

	class list_parse_scoreboard;
		phase_t                    phase;
		logic                      neg;
		base_t                     radix_sel;
		logic [63:0]               magnitude;
		logic                      mag_ovf;
		logic                      err_seen;
		logic [COUNT_BITS_DEF-1:0] parsed;
		number_result_t            staged;
		number_result_t            expected_numbers[$];
		int                        mismatches;
		int                        numbers_seen;
		int                        done_seen;
		int                        failed_seen;

		function new();
			reset_all();
			mismatches = 0;
			numbers_seen = 0;
			done_seen = 0;
			failed_seen = 0;
		endfunction

		function void clear_token();
			phase = PH_BETWEEN;
			neg = 1'b0;
			radix_sel = BASE_DEC;
			magnitude = '0;
			mag_ovf = 1'b0;
		endfunction

		function void reset_all();
			clear_token();
			err_seen = 1'b0;
			parsed = '0;
		endfunction

		function void fail_token();
			err_seen = 1'b1;
			clear_token();
		endfunction

		function int unsigned char_weight(logic [7:0] c);
			if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
			if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
			if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
			return 16;
		endfunction

		function int unsigned radix();
			if (radix_sel == BASE_HEX) return 16;
			if (radix_sel == BASE_OCT) return 8;
			return 10;
		endfunction

		function void begin_digits(base_t b, int unsigned d);
			phase = PH_DIGITS;
			radix_sel = b;
			magnitude = 64'(d);
		endfunction

		function void grow(int unsigned d);
			logic [63:0] lim;
			lim = 64'd1 << (LIMIT_BITS_DEF - 1);
			if (mag_ovf) return;
			if (magnitude > (lim - 64'(d)) / 64'(radix()))
				mag_ovf = 1'b1;
			else
				magnitude = magnitude * 64'(radix()) + 64'(d);
		endfunction

		// ends the current token, stages a number if it converts
		function bit close_token();
			logic [63:0] lim;
			logic [63:0] v;
			bit          fits;
			lim = 64'd1 << (LIMIT_BITS_DEF - 1);
			if (phase == PH_BETWEEN || phase == PH_ENDED) return 1'b0;
			if (phase != PH_ZERO && phase != PH_DIGITS) begin
				fail_token();
				return 1'b0;
			end
			fits = !mag_ovf && (neg ? magnitude <= lim : magnitude <= lim - 64'd1);
			if (!fits) begin
				fail_token();
				return 1'b0;
			end
			v = neg ? 64'd0 - magnitude : magnitude;
			staged.number_value = v[VALUE_BITS_DEF-1:0];
			staged.number_index = parsed;
			staged.value_valid = 1'b1;
			if (parsed != {COUNT_BITS_DEF{1'b1}}) parsed++;
			clear_token();
			return 1'b1;
		endfunction

		function bit take_byte(logic [7:0] c);
			int unsigned d;
			bit          ws;
			bit          got;
			d = char_weight(c);
			ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
			if (c == CH_NUL) begin
				got = close_token();
				if (!err_seen) phase = PH_ENDED;
				return got;
			end
			if (c == CH_COMMA) return close_token();
			case (phase)
				PH_BETWEEN, PH_SPACE: begin
					if (ws) begin
						phase = PH_SPACE;
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						phase = PH_SIGN;
						neg = (c == CH_MINUS);
					end else if (c == CH_ZERO) begin
						phase = PH_ZERO;
					end else if (d <= 9) begin
						begin_digits(BASE_DEC, d);
					end else begin
						fail_token();
					end
				end
				PH_SIGN: begin
					if (c == CH_ZERO) phase = PH_ZERO;
					else if (d <= 9) begin_digits(BASE_DEC, d);
					else fail_token();
				end
				PH_ZERO: begin
					if (c == CH_LX || c == CH_UX) phase = PH_HEXPFX;
					else if (d <= 7) begin_digits(BASE_OCT, d);
					else fail_token();
				end
				PH_HEXPFX: begin
					if (d <= 15) begin_digits(BASE_HEX, d);
					else fail_token();
				end
				PH_DIGITS: begin
					if (d < radix()) grow(d);
					else fail_token();
				end
				default: ;
			endcase
			return 1'b0;
		endfunction

		function void take_request(logic [7:0] c, logic present, logic eot);
			bit got;
			staged = '0;
			got = 1'b0;
			if (present && !err_seen && phase != PH_ENDED) got = take_byte(c);
			if (eot) begin
				if (!got && !err_seen) got = close_token();
				staged.done_res = 1'b1;
				staged.failed = err_seen;
				staged.number_count = parsed;
				reset_all();
				expected_numbers.push_back(staged);
			end else if (got) begin
				expected_numbers.push_back(staged);
			end
		endfunction

		function void compare_result(number_result_t got);
			number_result_t want;
			if (expected_numbers.size() == 0) begin
				$error("result with nothing expected: value %0h index %0d done %0b",
					got.number_value, got.number_index, got.done_res);
				mismatches++;
				return;
			end
			want = expected_numbers.pop_front();
			if (want.value_valid) numbers_seen++;
			if (want.done_res) done_seen++;
			if (want.failed) failed_seen++;
			if (got.number_value !== want.number_value) begin
				$error("number_value: expected %0h, got %0h", want.number_value, got.number_value);
				mismatches++;
			end
			if (got.number_index !== want.number_index) begin
				$error("number_index: expected %0d, got %0d", want.number_index, got.number_index);
				mismatches++;
			end
			if (got.value_valid !== want.value_valid) begin
				$error("value_valid: expected %0b, got %0b", want.value_valid, got.value_valid);
				mismatches++;
			end
			if (got.done_res !== want.done_res) begin
				$error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
				mismatches++;
			end
			if (got.failed !== want.failed) begin
				$error("failed: expected %0b, got %0b", want.failed, got.failed);
				mismatches++;
			end
			if (got.number_count !== want.number_count) begin
				$error("number_count: expected %0d, got %0d", want.number_count, got.number_count);
				mismatches++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [7:0]                char_code = 8'h00;
	logic                      char_present = 1'b0;
	logic                      end_of_text = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [VALUE_BITS_DEF-1:0] number_value;
	logic [COUNT_BITS_DEF-1:0] number_index;
	logic                      value_valid;
	logic                      done_res;
	logic                      failed;
	logic [COUNT_BITS_DEF-1:0] number_count;

	list_parse_scoreboard list_sb;
	byte unsigned         text_q[$];
	bit                   no_idle = 1'b0;
	bit                   noise_on = 1'b0;
	int unsigned          in_calm = 0;
	int unsigned          out_calm = 0;
	int unsigned          stall_left = 0;
	int unsigned          cycle_count = 0;
	int                   requests_sent = 0;
	int                   random_start;
	int                   texts_sent = 0;
	string                boundary_tokens[14] = '{
		"9223372036854775807", "9223372036854775808", "9223372036854775809",
		"0x7fffffffffffffff", "0X8000000000000000", "0x8000000000000001",
		"0777777777777777777777", "01000000000000000000000", "01000000000000000000001",
		"0xFFFFFFFFFFFFFFFF", "18446744073709551616", "4294967295", "2147483648",
		"0x80000000"
	};

	comma_separated_integer_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.char_present (char_present),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.number_value (number_value),
		.number_index (number_index),
		.value_valid  (value_valid),
		.done_res     (done_res),
		.failed       (failed),
		.number_count (number_count)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// mostly short gaps, a few long ones, and calm stretches with none
	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned r;
		if (calm != 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(30, 150);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 2);
		if (r < 97) return $urandom_range(3, 8);
		return $urandom_range(12, 40);
	endfunction

	always @(negedge clk) begin
		if (!arst_n || no_idle) begin
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap(out_calm);
		end
	end

	always @(posedge clk) begin
		number_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.number_value = number_value;
			got.number_index = number_index;
			got.value_valid = value_valid;
			got.done_res = done_res;
			got.failed = failed;
			got.number_count = number_count;
			list_sb.compare_result(got);
		end
	end

	task automatic send_item(input logic [7:0] c, input logic present, input logic eot);
		int unsigned gap;
		gap = no_idle ? 0 : pick_gap(in_calm);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
			char_code <= 8'($urandom);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		char_code <= c;
		char_present <= present;
		end_of_text <= eot;
		do @(posedge clk); while (in_stall);
		list_sb.take_request(c, present, eot);
		if (present || eot) requests_sent++;
	endtask

	task automatic send_text(input bit end_alone);
		int n;
		n = text_q.size();
		for (int i = 0; i < n; i++) begin
			if (noise_on && $urandom_range(0, 39) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(text_q[i], 1'b1, !end_alone && i == n - 1);
		end
		if (end_alone || n == 0) send_item(8'($urandom), 1'b0, 1'b1);
		text_q.delete();
		texts_sent++;
	endtask

	task automatic wait_all_results();
		@(negedge clk) in_valid <= 1'b0;
		while (list_sb.expected_numbers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void put_str(input string s);
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endfunction

	function automatic void put_token();
		byte unsigned tok[$];
		int unsigned  r;
		int unsigned  n;
		int unsigned  v;
		string        s;
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				r = $urandom_range(0, 5);
				tok.push_back(r == 5 ? CH_SPACE : CH_TAB + 8'(r));
			end
		end
		if ($urandom_range(0, 9) < 3) tok.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
		r = $urandom_range(0, 99);
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 22) : $urandom_range(0, 4);
		if (r < 35) begin
			tok.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
			repeat (n) tok.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
		end else if (r < 55) begin
			tok.push_back(CH_ZERO);
			repeat (n) tok.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
		end else if (r < 75) begin
			tok.push_back(CH_ZERO);
			tok.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
			repeat (n % 17 + 1) begin
				v = $urandom_range(0, 15);
				if (v < 10) tok.push_back(CH_ZERO + 8'(v));
				else tok.push_back(($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(v - 10));
			end
		end else if (r < 88) begin
			s = boundary_tokens[$urandom_range(0, 13)];
			for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
		end else if (r < 93) begin
			tok.push_back(CH_ZERO);
		end else if (r < 97) begin
			tok.push_back(CH_ZERO);
			tok.push_back(CH_LX);
		end else begin
			tok.push_back(CH_MINUS);
		end
		r = $urandom_range(0, 99);
		if (r < 8) tok.insert($urandom_range(0, tok.size()), 8'($urandom_range(1, 255)));
		else if (r < 11) tok.push_back(CH_SPACE);
		foreach (tok[i]) text_q.push_back(tok[i]);
	endfunction

	function automatic void put_text();
		int unsigned n;
		n = $urandom_range(1, 6);
		if ($urandom_range(0, 9) == 0) text_q.push_back(CH_COMMA);
		for (int unsigned k = 0; k < n; k++) begin
			put_token();
			if (k + 1 < n) begin
				text_q.push_back(CH_COMMA);
				if ($urandom_range(0, 9) == 0) text_q.push_back(CH_COMMA);
			end
		end
		if ($urandom_range(0, 6) == 0) text_q.push_back(CH_COMMA);
		if ($urandom_range(0, 19) == 0) begin
			text_q.push_back(CH_NUL);
			repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom));
		end
	endfunction

	task automatic run_directed();
		send_item(CH_NUL, 1'b0, 1'b1);
		put_str(" -0x1F,,017");
		send_text(1'b1);
		send_item(8'hFF, 1'b0, 1'b0);
		put_str("8,9");
		text_q.push_back(8'hFF);
		send_text(1'b0);
		text_q.push_back(CH_TAB);
		put_str("7");
		text_q.push_back(CH_NUL);
		put_str(",x");
		send_text(1'b0);
		put_str("08,5");
		send_text(1'b0);
	endtask

	// back-to-back list of one-digit numbers with no idle on either side
	task automatic run_burst();
		no_idle = 1'b1;
		for (int k = 0; k < BURST_TOKENS; k++) begin
			send_item(CH_ZERO + 8'($urandom_range(1, 9)), 1'b1, k == BURST_TOKENS - 1);
			if (k != BURST_TOKENS - 1) send_item(CH_COMMA, 1'b1, 1'b0);
		end
		texts_sent++;
		no_idle = 1'b0;
	endtask

	initial begin
		int errors;
		list_sb = new();
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		run_directed();
		wait_all_results();
		run_burst();
		wait_all_results();

		noise_on = 1'b1;
		random_start = requests_sent;
		while (requests_sent - random_start < RANDOM_REQUESTS) begin
			if ($urandom_range(0, 32) == 0) begin
				send_item(8'($urandom), 1'b0, 1'b1);
				texts_sent++;
			end else begin
				put_text();
				send_text($urandom_range(0, 9) < 3);
			end
			if ($urandom_range(0, 24) == 0) wait_all_results();
		end

		wait_all_results();
		repeat (8) @(posedge clk);
		errors = list_sb.mismatches + list_sb.expected_numbers.size();
		$display("%0d texts, %0d numbers and %0d done results checked, %0d failed texts",
			texts_sent, list_sb.numbers_seen, list_sb.done_seen, list_sb.failed_seen);
		$display("%0d-token burst with no gaps, %0d random requests with noise and stalls",
			BURST_TOKENS, requests_sent - random_start);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
